// ===== src/dse_pkg.sv =====
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and constants of the descriptive statistics engine.
// ----------------------------------------------------------------------------
package dse_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned VAR_W    = 48;
  localparam int unsigned STD_W    = 24;

  // Square-root remainder width: holds up to twice the partial root
  localparam int unsigned SQ_REM_W = STD_W + 2;

  // Parameter defaults
  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Sets that may wait between front end and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] average;
    logic        [VAR_W-1:0]    sample_variance;
    logic        [STD_W-1:0]    std_dev;
    logic        [COUNT_W-1:0]  count;
    logic                       single_sample;
    logic                       overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_MULN,
    BK_MULS,
    BK_VAR,
    BK_SQRT,
    BK_DONE
  } back_state_e;

endpackage

// ===== src/dse_front.sv =====
// ----------------------------------------------------------------------------
// dse_front
// Accumulates min, max, sum, sum of squares and count, one sample per cycle
// while the queue has room; the last sample hands the set to the queue.
// ----------------------------------------------------------------------------
module dse_front #(
  parameter int unsigned MAX_SAMPLES = dse_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = dse_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SUM_W = CNT_W + SAMPLE_BITS,
  localparam int unsigned SQ_W  = CNT_W + 2 * SAMPLE_BITS - 2,
  localparam int unsigned REC_W = 1 + CNT_W + SQ_W + SUM_W + 2 * SAMPLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dse_pkg::in_item_t in_data_i,
  output logic              rec_valid_o,
  input  logic              rec_ready_i,
  output logic [REC_W-1:0]  rec_data_o
);

  logic signed [SAMPLE_BITS-1:0] x;
  logic        [SAMPLE_BITS-1:0] ax;
  logic      [2*SAMPLE_BITS-1:0] ax_sq;

  logic signed [SAMPLE_BITS-1:0] min_q, min_d, min_n;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d, max_n;
  logic signed [SUM_W-1:0]       sum_q, sum_d, sum_n;
  logic        [SQ_W-1:0]        sq_q, sq_d, sq_n;
  logic        [CNT_W-1:0]       cnt_q, cnt_d, cnt_n;
  logic                          drop_q, drop_d, drop_n;

  logic full, first, accept;

  // Sign-extend from SAMPLE_BITS; upper payload bits are ignored
  assign x     = in_data_i.sample[SAMPLE_BITS-1:0];
  assign ax    = $unsigned(x[SAMPLE_BITS-1] ? -x : x);
  assign ax_sq = ax * ax;

  assign full   = (cnt_q == CNT_W'(MAX_SAMPLES));
  assign first  = (cnt_q == '0);
  assign accept = in_valid_i && in_ready_o;

  // Hold off samples only while the queue cannot take another set
  assign in_ready_o  = rec_ready_i;
  assign rec_valid_o = accept && in_data_i.last;
  assign rec_data_o  = {drop_n, cnt_n, sq_n, sum_n, max_n, min_n};

  always_comb begin
    min_n  = min_q;
    max_n  = max_q;
    sum_n  = sum_q;
    sq_n   = sq_q;
    cnt_n  = cnt_q;
    drop_n = drop_q | full;
    if (!full) begin
      if (first || (x < min_q)) min_n = x;
      if (first || (x > max_q)) max_n = x;
      sum_n = sum_q + SUM_W'(x);
      sq_n  = sq_q + SQ_W'(ax_sq);
      cnt_n = cnt_q + 1'b1;
    end
  end

  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    sum_d  = sum_q;
    sq_d   = sq_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (accept) begin
      if (in_data_i.last) begin
        // Set is complete: start over
        min_d  = '0;
        max_d  = '0;
        sum_d  = '0;
        sq_d   = '0;
        cnt_d  = '0;
        drop_d = 1'b0;
      end else begin
        min_d  = min_n;
        max_d  = max_n;
        sum_d  = sum_n;
        sq_d   = sq_n;
        cnt_d  = cnt_n;
        drop_d = drop_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== src/dse_queue.sv =====
// ----------------------------------------------------------------------------
// dse_queue
// Short first-in first-out queue of finished sets between the two ends.
// ----------------------------------------------------------------------------
module dse_queue #(
  parameter int unsigned DATA_W = 1,
  parameter int unsigned DEPTH  = dse_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned FILL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push, pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (fill_q != FILL_W'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q + FILL_W'(push) - FILL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/dse_back.sv =====
// ----------------------------------------------------------------------------
// dse_back
// Solves one queued set: mean by a bit-serial divider, N*S2 - S1^2 by a
// shift-add multiplier, variance by the same divider, then a bit-pair
// square root. Holds the result in an output register.
// ----------------------------------------------------------------------------
module dse_back #(
  parameter int unsigned MAX_SAMPLES = dse_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = dse_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SUM_W    = CNT_W + SAMPLE_BITS,
  localparam int unsigned SQ_W     = CNT_W + 2 * SAMPLE_BITS - 2,
  localparam int unsigned REC_W    = 1 + CNT_W + SQ_W + SUM_W + 2 * SAMPLE_BITS,
  localparam int unsigned NUM_W    = 2 * CNT_W + 2 * SAMPLE_BITS - 2,
  localparam int unsigned DEN_W    = 2 * CNT_W,
  localparam int unsigned STD_W    = dse_pkg::STD_W,
  localparam int unsigned VAR_W    = dse_pkg::VAR_W,
  localparam int unsigned SAMPLE_W = dse_pkg::SAMPLE_W,
  localparam int unsigned COUNT_W  = dse_pkg::COUNT_W,
  localparam int unsigned SQ_REM_W = dse_pkg::SQ_REM_W,
  localparam int unsigned SR_W     = SQ_REM_W + 2,
  localparam int unsigned STEP_MAX = (NUM_W > STD_W) ? NUM_W : STD_W,
  localparam int unsigned STEP_W   = $clog2(STEP_MAX)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  output logic               rec_ready_o,
  input  logic [REC_W-1:0]   rec_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dse_pkg::out_item_t out_data_o
);

  // Unpacked record
  logic signed [SAMPLE_BITS-1:0] r_min, r_max;
  logic signed [SUM_W-1:0]       r_sum;
  logic        [SQ_W-1:0]        r_sq;
  logic        [CNT_W-1:0]       r_cnt;
  logic                          r_drop;
  logic        [SUM_W-1:0]       r_mag;

  assign {r_drop, r_cnt, r_sq, r_sum, r_max, r_min} = rec_data_i;
  assign r_mag = $unsigned(r_sum[SUM_W-1] ? -r_sum : r_sum);

  dse_pkg::back_state_e state_q, state_d;

  logic [STEP_W-1:0]             step_q, step_d;
  logic [NUM_W-1:0]              acc_q, acc_d;
  logic [NUM_W-1:0]              mcand_q, mcand_d;
  logic [SUM_W-1:0]              mplier_q, mplier_d;
  logic [DEN_W-1:0]              rem_q, rem_d;
  logic [DEN_W-1:0]              div_q, div_d;
  logic [SUM_W-1:0]              mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic                          drop_q, drop_d;
  logic signed [SUM_W-1:0]       avg_q, avg_d;
  logic [VAR_W-1:0]              var_q, var_d;
  logic [VAR_W-1:0]              sqs_q, sqs_d;
  logic [SQ_REM_W-1:0]           sqr_q, sqr_d;
  logic [STD_W-1:0]              root_q, root_d;
  logic                          out_valid_q, out_valid_d;
  dse_pkg::out_item_t            out_q, out_d;

  // Shared restoring divider step
  logic [DEN_W:0] dv_sh, dv_diff;
  logic           dv_ge;
  assign dv_sh   = {rem_q, acc_q[NUM_W-1]};
  assign dv_diff = dv_sh - {1'b0, div_q};
  assign dv_ge   = (dv_sh >= {1'b0, div_q});

  // Shift-add multiplier step
  logic [NUM_W-1:0] mul_sum, mul_dif;
  assign mul_sum = acc_q + mcand_q;
  assign mul_dif = acc_q - mcand_q;

  // Square-root step, two radicand bits per cycle
  logic [SR_W-1:0] sr_sh, sr_trial, sr_diff;
  logic            sr_ge;
  assign sr_sh    = {sqr_q, sqs_q[VAR_W-1 -: 2]};
  assign sr_trial = SR_W'({root_q, 2'b01});
  assign sr_diff  = sr_sh - sr_trial;
  assign sr_ge    = (sr_sh >= sr_trial);

  // N * (N - 1), the variance divisor
  logic [DEN_W-1:0] nn;
  assign nn = {{CNT_W{1'b0}}, n_q} * {{CNT_W{1'b0}}, n_q - 1'b1};

  logic             last_step;
  logic [SUM_W-1:0] quo;
  assign last_step = (step_q == '0);
  assign quo       = {acc_q[SUM_W-2:0], dv_ge};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rem_d       = rem_q;
    div_d       = div_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    n_d         = n_q;
    min_d       = min_q;
    max_d       = max_q;
    drop_d      = drop_q;
    avg_d       = avg_q;
    var_d       = var_q;
    sqs_d       = sqs_q;
    sqr_d       = sqr_q;
    root_d      = root_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rec_ready_o = 1'b0;

    case (state_q)
      dse_pkg::BK_IDLE: begin
        rec_ready_o = 1'b1;
        if (rec_valid_i) begin
          min_d    = r_min;
          max_d    = r_max;
          drop_d   = r_drop;
          n_d      = r_cnt;
          neg_d    = r_sum[SUM_W-1];
          mag_d    = r_mag;
          // Place |sum| at the top so SUM_W steps leave the quotient low
          acc_d    = NUM_W'(r_mag) << (NUM_W - SUM_W);
          rem_d    = '0;
          div_d    = DEN_W'(r_cnt);
          mcand_d  = NUM_W'(r_sq);
          mplier_d = SUM_W'(r_cnt);
          step_d   = STEP_W'(SUM_W - 1);
          state_d  = dse_pkg::BK_AVG;
        end
      end

      dse_pkg::BK_AVG: begin
        rem_d  = dv_ge ? dv_diff[DEN_W-1:0] : dv_sh[DEN_W-1:0];
        acc_d  = {acc_q[NUM_W-2:0], dv_ge};
        step_d = step_q - 1'b1;
        if (last_step) begin
          avg_d   = neg_q ? -$signed(quo) : $signed(quo);
          acc_d   = '0;
          step_d  = STEP_W'(CNT_W - 1);
          state_d = dse_pkg::BK_MULN;
        end
      end

      dse_pkg::BK_MULN: begin
        // Accumulate N * S2
        if (mplier_q[0]) acc_d = mul_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) begin
          mcand_d  = NUM_W'(mag_q);
          mplier_d = mag_q;
          step_d   = STEP_W'(SUM_W - 1);
          state_d  = dse_pkg::BK_MULS;
        end
      end

      dse_pkg::BK_MULS: begin
        // Subtract S1 * S1; the final difference is never negative
        if (mplier_q[0]) acc_d = mul_dif;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) begin
          rem_d   = '0;
          div_d   = nn;
          step_d  = STEP_W'(NUM_W - 1);
          state_d = dse_pkg::BK_VAR;
        end
      end

      dse_pkg::BK_VAR: begin
        rem_d  = dv_ge ? dv_diff[DEN_W-1:0] : dv_sh[DEN_W-1:0];
        acc_d  = {acc_q[NUM_W-2:0], dv_ge};
        step_d = step_q - 1'b1;
        if (last_step) begin
          // Single sample: divisor is zero, force the variance to zero
          var_d   = (n_q == CNT_W'(1)) ? '0 : VAR_W'({acc_q[NUM_W-2:0], dv_ge});
          sqs_d   = var_d;
          sqr_d   = '0;
          root_d  = '0;
          step_d  = STEP_W'(STD_W - 1);
          state_d = dse_pkg::BK_SQRT;
        end
      end

      dse_pkg::BK_SQRT: begin
        sqr_d  = sr_ge ? sr_diff[SQ_REM_W-1:0] : sr_sh[SQ_REM_W-1:0];
        root_d = {root_q[STD_W-2:0], sr_ge};
        sqs_d  = sqs_q << 2;
        step_d = step_q - 1'b1;
        if (last_step) begin
          state_d = dse_pkg::BK_DONE;
        end
      end

      dse_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.minimum         = SAMPLE_W'(min_q);
          out_d.maximum         = SAMPLE_W'(max_q);
          out_d.average         = SAMPLE_W'(avg_q);
          out_d.sample_variance = var_q;
          out_d.std_dev         = root_q;
          out_d.count           = COUNT_W'(n_q);
          out_d.single_sample   = (n_q == CNT_W'(1));
          out_d.overflow        = drop_q;
          out_valid_d           = 1'b1;
          state_d               = dse_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = dse_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dse_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    n_q      <= n_d;
    min_q    <= min_d;
    max_q    <= max_d;
    drop_q   <= drop_d;
    avg_q    <= avg_d;
    var_q    <= var_d;
    sqs_q    <= sqs_d;
    sqr_q    <= sqr_d;
    root_q   <= root_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/descriptive_statistics_engine_top.sv =====
// ----------------------------------------------------------------------------
// descriptive_statistics_engine_top
// Min, max, mean, sample variance and standard deviation of sample sets.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one Q16.8 sample per
// transaction, last marks the end of a set. The front end accumulates one
// sample per cycle while the queue has room, squaring it combinationally.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction
// per set. After its last sample a set passes through the queue and the back
// end's AVG, MULN, MULS, VAR, SQRT and DONE states into the output register.
// The back end takes the next set only once back in idle, so it works on one
// set at a time in its bit-serial divider, multiplier and square-root loop.
// A queue of two sets decouples the ends; in_ready_o drops only while both
// queue slots are taken. When the receiver stalls, the output register holds
// the result, the back end waits with the next one, and the front end keeps
// accepting samples until the queue fills.
// Reset clears the accumulators, the queue and the output valid; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module descriptive_statistics_engine_top #(
  parameter int unsigned MAX_SAMPLES = dse_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = dse_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dse_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dse_pkg::out_item_t out_data_o
);

  // Record widths, matching the front and back ends
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = CNT_W + SAMPLE_BITS;
  localparam int unsigned SQ_W  = CNT_W + 2 * SAMPLE_BITS - 2;
  localparam int unsigned REC_W = 1 + CNT_W + SQ_W + SUM_W + 2 * SAMPLE_BITS;

  logic             push_valid, push_ready;
  logic [REC_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [REC_W-1:0] pop_data;

  // Front end: accept samples and close sets
  dse_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .rec_valid_o (push_valid),
    .rec_ready_i (push_ready),
    .rec_data_o  (push_data)
  );

  // Queue of finished sets
  dse_queue #(
    .DATA_W (REC_W),
    .DEPTH  (dse_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: solve each set and drive the result register
  dse_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (pop_valid),
    .rec_ready_o (pop_ready),
    .rec_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A closed set is waiting in the queue in the cycle after its last sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> pop_valid)
    else $error("closed set missing from queue");

  // Extremes come out ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.minimum <= out_data_o.maximum)
    else $error("minimum above maximum");

  // A one-sample set reports no spread
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.single_sample |->
      out_data_o.sample_variance == '0 && out_data_o.std_dev == '0)
    else $error("spread reported for a single sample");

  // Root never overshoots the variance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      48'(out_data_o.std_dev) * 48'(out_data_o.std_dev) <= out_data_o.sample_variance)
    else $error("standard deviation too large");

endmodule
